### hdl/dotl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotl_pkg
// Shared types, register indexes and reset values for the dual overcurrent
// trip latch.
// ----------------------------------------------------------------------------
package dotl_pkg;

    // field widths
    localparam int unsigned CUR_W    = 12;
    localparam int unsigned RUN_W    = 16;
    localparam int unsigned HOLD_W   = 11;
    localparam int unsigned TALLY_W  = 32;

    // configuration port widths
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP_WINDOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_HOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_CAP    = 3'd4;

    // register reset values
    localparam logic [CUR_W-1:0]  RST_THRESHOLD_A = 12'd1200;
    localparam logic [CUR_W-1:0]  RST_THRESHOLD_B = 12'd1200;
    localparam logic [RUN_W-1:0]  RST_TRIP_WINDOW = 16'd50;
    localparam logic [HOLD_W-1:0] RST_CLEAR_HOLD  = 11'd1000;
    localparam logic [HOLD_W-1:0] RST_HOLD_CAP    = 11'd1200;

    // one input item: two current samples and the clear button level
    typedef struct packed {
        logic [CUR_W-1:0] current_a;
        logic [CUR_W-1:0] current_b;
        logic             button_down;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic               fault_active;
        logic               tripped_now;
        logic               cleared_now;
        logic [TALLY_W-1:0] fault_total;
    } t_out_item;

    // current register settings
    typedef struct packed {
        logic [CUR_W-1:0]  threshold_a;
        logic [CUR_W-1:0]  threshold_b;
        logic [RUN_W-1:0]  trip_window;
        logic [HOLD_W-1:0] clear_hold;
        logic [HOLD_W-1:0] hold_cap;
    } t_cfg;

endpackage

### hdl/dual_overcurrent_trip_latch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_overcurrent_trip_latch
// Two-channel overcurrent trip latch with persistence window and
// hold-to-clear button; one result item per input item.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_ready    i_in_data  (t_in_item)
//   out       output     o_out_valid / i_out_ready  o_out_data (t_out_item)
//   cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An item waits in the input register and then moves to the result register,
// so its result is registered; one item per cycle is taken while the output
// side keeps up. Reset is synchronous and restores the register defaults and
// clears all counters. A stalled output holds its result, and the input
// register still accepts one more item behind it.
// ----------------------------------------------------------------------------
module dual_overcurrent_trip_latch (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dotl_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dotl_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dotl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dotl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dotl_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;
    t_cfg      cfg;
    t_out_item result;

    // item moves from input register to result register
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    dotl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // trip and clear state
    dotl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hdl/dotl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotl_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module dotl_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [dotl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dotl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output dotl_pkg::t_cfg                 o_cfg
);
    import dotl_pkg::*;

    t_cfg r_cfg;

    // register writes, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_a <= RST_THRESHOLD_A;
            r_cfg.threshold_b <= RST_THRESHOLD_B;
            r_cfg.trip_window <= RST_TRIP_WINDOW;
            r_cfg.clear_hold  <= RST_CLEAR_HOLD;
            r_cfg.hold_cap    <= RST_HOLD_CAP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD_A: r_cfg.threshold_a <= i_cfg_data[CUR_W-1:0];
                CFG_THRESHOLD_B: r_cfg.threshold_b <= i_cfg_data[CUR_W-1:0];
                CFG_TRIP_WINDOW: r_cfg.trip_window <= i_cfg_data[RUN_W-1:0];
                CFG_CLEAR_HOLD:  r_cfg.clear_hold  <= i_cfg_data[HOLD_W-1:0];
                CFG_HOLD_CAP:    r_cfg.hold_cap    <= i_cfg_data[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/dotl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotl_core
// Trip and clear state with its one-tick update; the result of the step
// is formed combinationally from the current state and the item.
// ----------------------------------------------------------------------------
module dotl_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  dotl_pkg::t_in_item  i_item,
    input  dotl_pkg::t_cfg      i_cfg,
    output dotl_pkg::t_out_item o_result
);
    import dotl_pkg::*;

    logic [RUN_W-1:0]   r_run_a, n_run_a;
    logic [RUN_W-1:0]   r_run_b, n_run_b;
    logic               r_faulted, n_faulted;
    logic [HOLD_W-1:0]  r_hold, n_hold;
    logic [TALLY_W-1:0] r_tally, n_tally;
    logic               tripped;
    logic               cleared;
    logic [RUN_W-1:0]   run_a_upd;
    logic [RUN_W-1:0]   run_b_upd;
    logic [HOLD_W-1:0]  hold_upd;

    // run counters, saturating, zeroed at or below threshold
    always_comb begin
        run_a_upd = '0;
        run_b_upd = '0;
        if (i_item.current_a > i_cfg.threshold_a) begin
            run_a_upd = (&r_run_a) ? r_run_a : r_run_a + 1'b1;
        end
        if (i_item.current_b > i_cfg.threshold_b) begin
            run_b_upd = (&r_run_b) ? r_run_b : r_run_b + 1'b1;
        end
    end

    // trip, hold and clear decision
    always_comb begin
        n_run_a   = run_a_upd;
        n_run_b   = run_b_upd;
        n_faulted = r_faulted;
        n_hold    = r_hold;
        n_tally   = r_tally;
        tripped   = 1'b0;
        cleared   = 1'b0;
        hold_upd  = (r_hold < i_cfg.hold_cap) ? r_hold + 1'b1 : r_hold;
        priority if (!r_faulted) begin
            if (run_a_upd >= i_cfg.trip_window || run_b_upd >= i_cfg.trip_window) begin
                n_faulted = 1'b1;
                tripped   = 1'b1;
                n_tally   = (&r_tally) ? r_tally : r_tally + 1'b1;
            end
        end else if (i_item.button_down) begin
            n_hold = hold_upd;
            if (hold_upd >= i_cfg.clear_hold) begin
                n_faulted = 1'b0;
                n_run_a   = '0;
                n_run_b   = '0;
                n_hold    = '0;
                cleared   = 1'b1;
            end
        end else begin
            n_hold = '0;
        end
    end

    // state registers, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_a   <= '0;
            r_run_b   <= '0;
            r_faulted <= 1'b0;
            r_hold    <= '0;
            r_tally   <= '0;
        end else if (i_step) begin
            r_run_a   <= n_run_a;
            r_run_b   <= n_run_b;
            r_faulted <= n_faulted;
            r_hold    <= n_hold;
            r_tally   <= n_tally;
        end
    end

    assign o_result.fault_active = n_faulted;
    assign o_result.tripped_now  = tripped;
    assign o_result.cleared_now  = cleared;
    assign o_result.fault_total  = n_tally;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual overcurrent trip latch. A scoreboard keeps
// its own copy of the run, hold and tally counters, predicts the result of
// every accepted tick, and compares each delivered result field by field.
// Stimulus is a short directed part, then trip / hold / clear episodes with
// random content under fixed extreme settings and random settings, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_top;
    import dotl_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 500000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RANDOM_TICKS  = 640;
    localparam int unsigned N_FIXED       = 8;
    localparam int unsigned SHORT_SIZE    = 64;
    localparam int unsigned IDLE_PCT      = 18;
    localparam int unsigned QUIET_FROM    = 320;
    localparam int unsigned QUIET_TO      = 480;

    // ------------------------------------------------------------------------
    // scoreboard: mirrored counters and the results still due
    // ------------------------------------------------------------------------
    class trip_scoreboard;
        localparam int MAX_LINES = 40;

        t_cfg               cfg;
        logic [RUN_W-1:0]   run_a;
        logic [RUN_W-1:0]   run_b;
        logic               faulted;
        logic [HOLD_W-1:0]  hold;
        logic [TALLY_W-1:0] tally;
        t_out_item          due_results[$];
        int                 errors;
        int                 n_checked;

        function new();
            cfg.threshold_a = RST_THRESHOLD_A;
            cfg.threshold_b = RST_THRESHOLD_B;
            cfg.trip_window = RST_TRIP_WINDOW;
            cfg.clear_hold  = RST_CLEAR_HOLD;
            cfg.hold_cap    = RST_HOLD_CAP;
            run_a     = '0;
            run_b     = '0;
            faulted   = 1'b0;
            hold      = '0;
            tally     = '0;
            errors    = 0;
            n_checked = 0;
        endfunction

        // register write, masked to the register width; unused indexes drop
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_THRESHOLD_A: cfg.threshold_a = data[CUR_W-1:0];
                CFG_THRESHOLD_B: cfg.threshold_b = data[CUR_W-1:0];
                CFG_TRIP_WINDOW: cfg.trip_window = data[RUN_W-1:0];
                CFG_CLEAR_HOLD:  cfg.clear_hold  = data[HOLD_W-1:0];
                CFG_HOLD_CAP:    cfg.hold_cap    = data[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        // consecutive over-threshold count, sticking at full scale
        function logic [RUN_W-1:0] bump_run(logic [RUN_W-1:0] run, logic [CUR_W-1:0] s,
                                            logic [CUR_W-1:0] thr);
            if (s > thr) begin
                return (run == '1) ? run : run + 1'b1;
            end
            return '0;
        endfunction

        // one tick of the latch
        function t_out_item advance_tick(t_in_item it);
            t_out_item r;
            r = '0;
            run_a = bump_run(run_a, it.current_a, cfg.threshold_a);
            run_b = bump_run(run_b, it.current_b, cfg.threshold_b);
            if (!faulted) begin
                if (run_a >= cfg.trip_window || run_b >= cfg.trip_window) begin
                    faulted       = 1'b1;
                    r.tripped_now = 1'b1;
                    if (tally != '1) tally = tally + 1'b1;
                end
            end else if (it.button_down) begin
                if (hold < cfg.hold_cap) hold = hold + 1'b1;
                if (hold >= cfg.clear_hold) begin
                    faulted       = 1'b0;
                    run_a         = '0;
                    run_b         = '0;
                    hold          = '0;
                    r.cleared_now = 1'b1;
                end
            end else begin
                hold = '0;
            end
            r.fault_active = faulted;
            r.fault_total  = tally;
            return r;
        endfunction

        function void note_tick(t_in_item it);
            due_results.push_back(advance_tick(it));
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_LINES) $display("tb_top: %s", msg);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                report($sformatf("result with nothing due: fault %0b total %0d",
                                 got.fault_active, got.fault_total));
                return;
            end
            want = due_results.pop_front();
            if (got.fault_active !== want.fault_active)
                report($sformatf("result %0d fault_active %b, want %b",
                                 n_checked, got.fault_active, want.fault_active));
            if (got.tripped_now !== want.tripped_now)
                report($sformatf("result %0d tripped_now %b, want %b",
                                 n_checked, got.tripped_now, want.tripped_now));
            if (got.cleared_now !== want.cleared_now)
                report($sformatf("result %0d cleared_now %b, want %b",
                                 n_checked, got.cleared_now, want.cleared_now));
            if (got.fault_total !== want.fault_total)
                report($sformatf("result %0d fault_total %0d, want %0d",
                                 n_checked, got.fault_total, want.fault_total));
            n_checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, block inputs and the instance
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  o_cfg_ready;

    trip_scoreboard        trip_sb;
    int unsigned           ticks_sent   = 0;
    int unsigned           cycle_count  = 0;
    logic                  no_stall     = 1'b0;

    always #1 i_clk = ~i_clk;

    dual_overcurrent_trip_latch u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // output side: random stalls except during the quiet stretch
    always @(posedge i_clk) begin
        i_out_ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
    end

    // accepted ticks and delivered results, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) trip_sb.note_tick(i_in_data);
            if (o_out_valid && i_out_ready) trip_sb.check_result(o_out_data);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("dual_overcurrent_trip_latch: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    function t_in_item mk_tick(int unsigned a, int unsigned b, bit btn);
        t_in_item it;
        it.current_a   = a[CUR_W-1:0];
        it.current_b   = b[CUR_W-1:0];
        it.button_down = btn;
        return it;
    endfunction

    // one tick on the input channel, with an occasional gap in front
    task send_tick(t_in_item it);
        bit quiet;
        quiet = (ticks_sent >= QUIET_FROM && ticks_sent < QUIET_TO);
        no_stall <= quiet;
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        ticks_sent++;
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        trip_sb.set_reg(idx, data);
    endtask

    // all five registers, with junk above the width of each narrower one, plus an unused index
    task apply_cfg(t_cfg c);
        i_in_valid <= 1'b0;
        write_reg(CFG_THRESHOLD_A, {4'($urandom), c.threshold_a});
        write_reg(CFG_THRESHOLD_B, {4'($urandom), c.threshold_b});
        write_reg(CFG_TRIP_WINDOW, c.trip_window);
        write_reg(CFG_CLEAR_HOLD, {5'($urandom), c.clear_hold});
        write_reg(CFG_HOLD_CAP, {5'($urandom), c.hold_cap});
        write_reg(CFG_HOLD_CAP + 3'($urandom_range(1, 3)), 16'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        while (trip_sb.due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // sample pickers around a threshold
    // ------------------------------------------------------------------------
    function int unsigned pick_over(logic [CUR_W-1:0] thr);
        if (thr == '1) return thr;
        case ($urandom_range(0, 2))
            0:       return thr + 1;
            1:       return 4095;
            default: return $urandom_range(thr + 1, 4095);
        endcase
    endfunction

    function int unsigned pick_under(logic [CUR_W-1:0] thr);
        case ($urandom_range(0, 2))
            0:       return thr;
            1:       return 0;
            default: return $urandom_range(0, thr);
        endcase
    endfunction

    function int unsigned pick_noise(logic [CUR_W-1:0] thr, int unsigned over_pct);
        if ($urandom_range(99) < over_pct) return pick_over(thr);
        return pick_under(thr);
    endfunction

    // over-threshold run, button hold (sometimes released early), short tail
    task run_episode();
        int unsigned ch;
        int unsigned over_len;
        int unsigned hold_len;
        t_cfg        c;
        c  = trip_sb.cfg;
        ch = $urandom_range(0, 2);
        if (c.trip_window > SHORT_SIZE) over_len = $urandom_range(1, 20);
        else over_len = c.trip_window + $urandom_range(1, 3) - 1;
        if (over_len == 0) over_len = 1;
        for (int unsigned i = 0; i < over_len; i++) begin
            send_tick(mk_tick(ch != 1 ? pick_over(c.threshold_a) : pick_noise(c.threshold_a, 30),
                              ch != 0 ? pick_over(c.threshold_b) : pick_noise(c.threshold_b, 30),
                              1'($urandom)));
        end
        if (c.trip_window > SHORT_SIZE) hold_len = $urandom_range(0, 3);
        else if (c.clear_hold <= SHORT_SIZE && $urandom_range(0, 3) == 0)
            hold_len = $urandom_range(0, c.clear_hold);
        else hold_len = c.clear_hold + $urandom_range(0, 2);
        for (int unsigned i = 0; i < hold_len; i++) begin
            send_tick(mk_tick(pick_noise(c.threshold_a, 20), pick_noise(c.threshold_b, 20), 1'b1));
        end
        send_tick(mk_tick(pick_noise(c.threshold_a, 20), pick_noise(c.threshold_b, 20), 1'b0));
        repeat ($urandom_range(0, 2)) begin
            send_tick(mk_tick(pick_noise(c.threshold_a, 30), pick_noise(c.threshold_b, 30),
                              1'($urandom)));
        end
    endtask

    task run_phase(int unsigned n);
        int unsigned start;
        start = ticks_sent;
        do run_episode(); while (ticks_sent - start < n);
    endtask

    // extreme settings: zeros, full scale, cap below clear, long hold
    function t_cfg fixed_setting(int unsigned k);
        case (k)
            0:       return '{12'd0,    12'd4095, 16'd1,     11'd1,    11'd1};
            1:       return '{12'd4095, 12'd0,    16'd2,     11'd3,    11'd5};
            2:       return '{12'd1200, 12'd1200, 16'd3,     11'd4,    11'd2};
            3:       return '{12'd2048, 12'd100,  16'd0,     11'd0,    11'd0};
            4:       return '{12'd100,  12'd2048, 16'd4,     11'd0,    11'd3};
            5:       return '{12'd500,  12'd500,  16'd2,     11'd3,    11'd0};
            6:       return '{12'd0,    12'd0,    16'd65535, 11'd2047, 11'd2047};
            default: return '{12'd3000, 12'd10,   16'd1,     11'd100,  11'd2047};
        endcase
    endfunction

    function t_cfg random_setting();
        t_cfg c;
        c.threshold_a = ($urandom_range(0, 4) == 0) ? 12'd0 : 12'($urandom);
        c.threshold_b = ($urandom_range(0, 4) == 0) ? 12'd4095 : 12'($urandom);
        c.trip_window = 16'($urandom_range(0, 8));
        c.clear_hold  = 11'($urandom_range(0, 10));
        c.hold_cap    = 11'($urandom_range(0, 12));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_cfg        c;
        int unsigned directed_ticks;
        int unsigned long_ticks;
        int unsigned mark;

        trip_sb    = new();
        long_ticks = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: field extremes and threshold edges, no trip yet
        send_tick(mk_tick(0, 0, 0));
        send_tick(mk_tick(4095, 4095, 1));
        send_tick(mk_tick(1200, 1201, 0));
        send_tick(mk_tick(1201, 1200, 1));
        wait_drained();

        // trip on channel a; button on the trip tick is ignored; partial hold
        apply_cfg('{12'd100, 12'd200, 16'd2, 11'd6, 11'd10});
        send_tick(mk_tick(101, 0, 0));
        send_tick(mk_tick(4095, 0, 1));
        repeat (5) send_tick(mk_tick(0, 0, 1));
        wait_drained();

        // hold count above a lowered cap still clears; then trip on channel b
        apply_cfg('{12'd100, 12'd200, 16'd2, 11'd4, 11'd2});
        send_tick(mk_tick(0, 0, 1));
        send_tick(mk_tick(0, 201, 0));
        send_tick(mk_tick(0, 4095, 0));
        send_tick(mk_tick(0, 0, 0));
        wait_drained();

        // zero window, zero clear hold, zero cap
        apply_cfg('{12'd100, 12'd200, 16'd0, 11'd0, 11'd0});
        send_tick(mk_tick(0, 0, 1));
        send_tick(mk_tick(0, 0, 0));
        send_tick(mk_tick(0, 0, 0));
        wait_drained();
        directed_ticks = ticks_sent;

        // fixed extreme settings
        for (int unsigned k = 0; k < N_FIXED; k++) begin
            c = fixed_setting(k);
            apply_cfg(c);
            if (c.trip_window > SHORT_SIZE) begin
                run_phase(40);
            end else if (c.clear_hold > SHORT_SIZE) begin
                mark = ticks_sent;
                run_phase(1);
                long_ticks += ticks_sent - mark;
            end else begin
                run_phase(60);
            end
            wait_drained();
        end

        // random settings
        while (ticks_sent - directed_ticks - long_ticks < RANDOM_TICKS) begin
            apply_cfg(random_setting());
            run_phase(60);
            wait_drained();
        end

        if (trip_sb.errors == 0) begin
            $display("dual_overcurrent_trip_latch: match");
        end else begin
            $display("dual_overcurrent_trip_latch: mismatch");
        end
        $finish;
    end

endmodule
